// File: rtl/core/fat16ca_pkg.sv
package fat16ca_pkg;

  localparam int TABLE_DEPTH_DEF = 512;

  localparam logic [15:0] END_MARK    = 16'hFFF8;
  localparam logic [15:0] SECOND_MARK = 16'hFFFF;
  localparam int          FIRST_ALLOC = 2;

  localparam logic [1:0] ACT_FORMAT = 2'd0;
  localparam logic [1:0] ACT_ALLOC  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;

  localparam logic CFG_USABLE = 1'b0;
  localparam logic CFG_CSIZE  = 1'b1;

  localparam logic [9:0] USABLE_RESET = 10'd415;
  localparam logic [3:0] CSIZE_RESET  = 4'd9;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] byte_count;
    logic [8:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  head_cluster;
    logic [15:0] entry_value;
    logic [9:0]  free_count;
  } rsp_t;

endpackage

// File: rtl/core/fat16ca_ram.sv
module fat16ca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = fat16ca_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/fat16_cluster_chain_allocator_core.sv
// Steps: format clears the whole table; any other action first counts free
// entries below lim = min(usable_clusters, TABLE_DEPTH); then a read fetches its
// entry, an allocate links its chain in a second scan, and a failed allocate,
// out-of-range read or unused action returns. One item at a time; each scan reads
// one table entry per cycle through the single read port. The result register
// lets the next beat in. Reset: synchronous; then a clearing pass, req_stall high.
module fat16_cluster_chain_allocator_core #(
  parameter int TABLE_DEPTH = fat16ca_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  fat16ca_pkg::req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output fat16ca_pkg::rsp_t rsp,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [9:0]        cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > 10) ? CW : 10;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_COUNT     = 4'd2;
  localparam logic [3:0] S_DECIDE    = 4'd3;
  localparam logic [3:0] S_ALLOC     = 4'd4;
  localparam logic [3:0] S_ALLOC_END = 4'd5;
  localparam logic [3:0] S_READ      = 4'd6;
  localparam logic [3:0] S_READ_WAIT = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]    state;
  logic [9:0]    usable_clusters;
  logic [3:0]    cluster_size_log2;
  logic [CW-1:0] lim;
  logic [LW-1:0] lim_w;
  logic [CW-1:0] ptr;
  logic          rd_vld;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] prev;
  logic          have_prev;
  logic [9:0]    free_cnt;
  logic [1:0]    act;
  logic [8:0]    idx;
  logic [9:0]    need;
  logic          need_big;
  logic [9:0]    need_left;
  logic [1:0]    stat;
  logic [8:0]    head;
  logic [15:0]   value;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic [31:0]   quot;
  logic          rem;
  logic [32:0]   need_full;
  logic          ptr_in;
  logic          hit;

  always_comb begin
    if (LW'(usable_clusters) > LW'(TABLE_DEPTH)) begin
      lim_w = LW'(TABLE_DEPTH);
    end else begin
      lim_w = LW'(usable_clusters);
    end
    lim = lim_w[CW-1:0];
  end

  always_comb begin
    quot      = req.byte_count >> cluster_size_log2;
    rem       = |(req.byte_count & ((32'd1 << cluster_size_log2) - 32'd1));
    need_full = {1'b0, quot} + {32'd0, rem};
    if (need_full == 33'd0) begin
      need_full = 33'd1;
    end
  end

  assign ptr_in    = (ptr < lim);
  assign hit       = rd_vld && (ram_rdata == 16'd0) && (need_left != 10'd0);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = 16'd0;
    ram_raddr = ptr[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (ptr == CW'(0)) begin
          ram_wdata = fat16ca_pkg::END_MARK;
        end else if (ptr == CW'(1)) begin
          ram_wdata = fat16ca_pkg::SECOND_MARK;
        end
      end
      S_ALLOC: begin
        if (hit && have_prev) begin
          ram_we    = 1'b1;
          ram_waddr = prev;
          ram_wdata = 16'(rd_addr);
        end
      end
      S_ALLOC_END: begin
        ram_we    = 1'b1;
        ram_waddr = prev;
        ram_wdata = fat16ca_pkg::END_MARK;
      end
      S_READ: ram_raddr = AW'(idx);
      default: ;
    endcase
  end

  fat16ca_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      ptr               <= '0;
      act               <= fat16ca_pkg::ACT_NONE;
      rsp_valid         <= 1'b0;
      rd_vld            <= 1'b0;
      have_prev         <= 1'b0;
      usable_clusters   <= fat16ca_pkg::USABLE_RESET;
      cluster_size_log2 <= fat16ca_pkg::CSIZE_RESET;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == fat16ca_pkg::CFG_USABLE) begin
          usable_clusters <= cfg_data;
        end else begin
          cluster_size_log2 <= cfg_data[3:0];
        end
      end
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + CW'(1);
          if (ptr == CW'(TABLE_DEPTH - 1)) begin
            if (act == fat16ca_pkg::ACT_FORMAT) begin
              free_cnt <= (lim > CW'(2)) ? 10'(lim - CW'(2)) : 10'd0;
              state    <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            act       <= req.action;
            idx       <= req.entry_index;
            need      <= need_full[9:0];
            need_big  <= |need_full[32:10];
            stat      <= fat16ca_pkg::STAT_OK;
            head      <= 9'd0;
            value     <= 16'd0;
            have_prev <= 1'b0;
            rd_vld    <= 1'b0;
            free_cnt  <= 10'd0;
            if (req.action == fat16ca_pkg::ACT_FORMAT) begin
              ptr   <= '0;
              state <= S_CLEAR;
            end else begin
              ptr   <= CW'(fat16ca_pkg::FIRST_ALLOC);
              state <= S_COUNT;
            end
          end
        end
        S_COUNT: begin
          rd_vld  <= ptr_in;
          rd_addr <= ptr[AW-1:0];
          if (ptr_in) begin
            ptr <= ptr + CW'(1);
          end
          if (rd_vld && ram_rdata == 16'd0) begin
            free_cnt <= free_cnt + 10'd1;
          end
          if (!ptr_in && !rd_vld) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          unique case (act)
            fat16ca_pkg::ACT_ALLOC: begin
              if (need_big || need > free_cnt) begin
                stat  <= fat16ca_pkg::STAT_NO_SPACE;
                state <= S_DONE;
              end else begin
                ptr       <= CW'(fat16ca_pkg::FIRST_ALLOC);
                rd_vld    <= 1'b0;
                need_left <= need;
                state     <= S_ALLOC;
              end
            end
            fat16ca_pkg::ACT_READ: begin
              if (LW'(idx) >= LW'(lim)) begin
                stat  <= fat16ca_pkg::STAT_RANGE;
                state <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_ALLOC: begin
          rd_vld  <= ptr_in;
          rd_addr <= ptr[AW-1:0];
          if (ptr_in) begin
            ptr <= ptr + CW'(1);
          end
          if (hit) begin
            if (!have_prev) begin
              head <= 9'(rd_addr);
            end
            have_prev <= 1'b1;
            prev      <= rd_addr;
            need_left <= need_left - 10'd1;
            if (need_left == 10'd1) begin
              state <= S_ALLOC_END;
            end
          end
        end
        S_ALLOC_END: begin
          free_cnt <= free_cnt - need;
          state    <= S_DONE;
        end
        S_READ: state <= S_READ_WAIT;
        S_READ_WAIT: begin
          value <= ram_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status       <= stat;
            rsp.head_cluster <= head;
            rsp.entry_value  <= value;
            rsp.free_count   <= free_cnt;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/fat16ca_chk.sv
module fat16ca_chk (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input fat16ca_pkg::rsp_t rsp
);

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // clearing pass follows reset
  a_clear_after_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> req_stall)
    else $error("request taken during clearing pass");

  a_no_space_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == fat16ca_pkg::STAT_NO_SPACE |->
      rsp.head_cluster == 9'd0 && rsp.entry_value == 16'd0)
    else $error("failed allocate returned a chain");

  a_range_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == fat16ca_pkg::STAT_RANGE |->
      rsp.entry_value == 16'd0 && rsp.head_cluster == 9'd0)
    else $error("out of range read returned data");

  // one item at a time: a request beat is followed by a stalled port
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request beat taken back to back");

endmodule

bind fat16_cluster_chain_allocator_core fat16ca_chk u_fat16ca_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// File: tb/tb_fat16_cluster_chain_allocator_core.sv
`timescale 1ns / 100ps

module tb_fat16_cluster_chain_allocator_core;

  localparam int DEPTH = fat16ca_pkg::TABLE_DEPTH_DEF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  fat16ca_pkg::req_t req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  fat16ca_pkg::rsp_t rsp;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = 1'b0;
  logic [9:0]        cfg_data = '0;

  fat16_cluster_chain_allocator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the allocation table and registers
  logic [15:0] fat_mirror [DEPTH];
  logic [9:0]  cfg_usable = fat16ca_pkg::USABLE_RESET;
  logic [3:0]  cfg_csize = fat16ca_pkg::CSIZE_RESET;

  fat16ca_pkg::rsp_t pending_rsp [$];
  int unsigned err_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_hold = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stall_on = 1'b1;

  function automatic void wipe_mirror();
    for (int i = 0; i < DEPTH; i++) fat_mirror[i] = '0;
    fat_mirror[0] = fat16ca_pkg::END_MARK;
    fat_mirror[1] = fat16ca_pkg::SECOND_MARK;
  endfunction

  function automatic int unsigned usable_lim();
    return (cfg_usable > DEPTH) ? DEPTH : cfg_usable;
  endfunction

  function automatic logic [9:0] count_free();
    int unsigned n = 0;
    for (int i = fat16ca_pkg::FIRST_ALLOC; i < usable_lim(); i++) begin
      if (fat_mirror[i] == 16'h0000) n++;
    end
    return n[9:0];
  endfunction

  function automatic fat16ca_pkg::rsp_t chain_predict(fat16ca_pkg::req_t r);
    fat16ca_pkg::rsp_t e;
    int unsigned       lim;
    longint unsigned   bytes;
    longint unsigned   need;
    int unsigned       prev;
    bit                have_prev;
    e = '0;
    lim = usable_lim();
    bytes = r.byte_count;
    prev = 0;
    have_prev = 1'b0;
    case (r.action)
      fat16ca_pkg::ACT_FORMAT: begin
        wipe_mirror();
      end
      fat16ca_pkg::ACT_ALLOC: begin
        need = (bytes >> cfg_csize) + (((bytes & ((64'd1 << cfg_csize) - 1)) != 0) ? 1 : 0);
        if (need == 0) need = 1;
        if (need > count_free()) begin
          e.status = fat16ca_pkg::STAT_NO_SPACE;
        end else begin
          for (int i = fat16ca_pkg::FIRST_ALLOC; i < lim && need > 0; i++) begin
            if (fat_mirror[i] != 16'h0000) continue;
            if (have_prev) fat_mirror[prev] = 16'(i);
            else e.head_cluster = i[8:0];
            fat_mirror[i] = fat16ca_pkg::END_MARK;
            prev = i;
            have_prev = 1'b1;
            need--;
          end
        end
      end
      fat16ca_pkg::ACT_READ: begin
        if (r.entry_index >= lim) e.status = fat16ca_pkg::STAT_RANGE;
        else e.entry_value = fat_mirror[r.entry_index];
      end
      default: begin
      end
    endcase
    e.free_count = count_free();
    return e;
  endfunction

  function automatic fat16ca_pkg::req_t make_req(logic [1:0] a, logic [31:0] b,
                                                 logic [8:0] i);
    fat16ca_pkg::req_t r;
    r.action = a;
    r.byte_count = b;
    r.entry_index = i;
    return r;
  endfunction

  function automatic logic [31:0] pick_bytes();
    int unsigned csz;
    csz = 1 << cfg_csize;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2, 3: return $urandom_range(1, 4) * csz;
      4: return $urandom_range(0, 3) * csz + 1;
      5: return $urandom_range(0, usable_lim()) * csz;
      default: return $urandom_range(0, 4 * csz);
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Receiver: random stall runs, held for a random number of cycles
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      rsp_stall <= rx_stall_on && ($urandom_range(0, 2) == 0);
      stall_hold <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    fat16ca_pkg::rsp_t want;
    if (rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t result beat with none expected: expected none, got %h", $time, rsp);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", 16'(want.status), 16'(rsp.status));
        check_field("head_cluster", 16'(want.head_cluster), 16'(rsp.head_cluster));
        check_field("entry_value", want.entry_value, rsp.entry_value);
        check_field("free_count", 16'(want.free_count), 16'(rsp.free_count));
      end
    end
  end

  task automatic send_req(input fat16ca_pkg::req_t r, output fat16ca_pkg::rsp_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = tx_gaps_on ? $urandom_range(0, 30) : 0;
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    e = chain_predict(r);
    pending_rsp.push_back(e);
    burst_left--;
  endtask

  task automatic drain(input int unsigned settle);
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic i, input logic [9:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    if (i == fat16ca_pkg::CFG_USABLE) cfg_usable = d;
    else cfg_csize = d[3:0];
  endtask

  task automatic configure(input logic [9:0] usable, input logic [3:0] csize);
    drain(8);
    write_reg(fat16ca_pkg::CFG_USABLE, usable);
    write_reg(fat16ca_pkg::CFG_CSIZE, {6'd0, csize});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reads_at_reset();
    fat16ca_pkg::rsp_t e;
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd0), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'hFFFF_FFFF, 9'd1), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd414), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd415), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd511), e);
  endtask

  task automatic test_alloc_edges();
    fat16ca_pkg::rsp_t e;
    logic [8:0]        head;
    send_req(make_req(fat16ca_pkg::ACT_ALLOC, 32'd0, 9'd0), e);
    send_req(make_req(fat16ca_pkg::ACT_ALLOC, 32'd512, 9'h1FF), e);
    send_req(make_req(fat16ca_pkg::ACT_ALLOC, 32'd513, 9'd0), e);
    head = e.head_cluster;
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, head), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, fat_mirror[head][8:0]), e);
    send_req(make_req(fat16ca_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 9'd0), e);
    send_req(make_req(fat16ca_pkg::ACT_NONE, $urandom, 9'($urandom)), e);
    send_req(make_req(fat16ca_pkg::ACT_FORMAT, $urandom, 9'($urandom)), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd2), e);
    // fill every usable cluster, then one more must fail
    send_req(make_req(fat16ca_pkg::ACT_ALLOC, 32'd413 * 32'd512, 9'd0), e);
    send_req(make_req(fat16ca_pkg::ACT_ALLOC, 32'd0, 9'd0), e);
  endtask

  task automatic test_limits();
    fat16ca_pkg::rsp_t e;
    configure(10'd2, 4'd15);
    send_req(make_req(fat16ca_pkg::ACT_ALLOC, 32'd0, 9'd0), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd1), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd2), e);
    configure(10'd512, 4'd9);
    send_req(make_req(fat16ca_pkg::ACT_FORMAT, 32'd0, 9'd0), e);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd511), e);
    configure(10'd1023, 4'd15);
    send_req(make_req(fat16ca_pkg::ACT_READ, 32'd0, 9'd511), e);
  endtask

  task automatic test_random();
    int unsigned       use_tab [12] = '{40, 2, 512, 1, 24, 1023, 415, 9, 130, 60, 300, 17};
    int unsigned       csz_tab [12] = '{9, 15, 12, 9, 0, 15, 10, 11, 13, 14, 9, 12};
    fat16ca_pkg::rsp_t e;
    int unsigned       sent;
    int unsigned       pick;
    int unsigned       lim;
    int unsigned       steps;
    logic [8:0]        idx;
    for (int p = 0; p < 12; p++) begin
      tx_gaps_on = (p % 4 != 1);
      rx_stall_on = (p % 4 != 1);
      configure(10'(use_tab[p]), 4'(csz_tab[p]));
      sent = 0;
      while (sent < 46) begin
        lim = usable_lim();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_req(make_req(fat16ca_pkg::ACT_ALLOC, pick_bytes(), 9'($urandom)), e);
          sent++;
          // follow the new chain for a few links
          if (e.status == fat16ca_pkg::STAT_OK && $urandom_range(0, 2) == 0) begin
            idx = e.head_cluster;
            steps = $urandom_range(1, 6);
            repeat (steps) begin
              send_req(make_req(fat16ca_pkg::ACT_READ, $urandom, idx), e);
              sent++;
              if (fat_mirror[idx] == fat16ca_pkg::END_MARK) break;
              idx = fat_mirror[idx][8:0];
            end
          end
        end else if (pick < 88) begin
          if ($urandom_range(0, 9) == 0 || lim == 0)
            idx = 9'($urandom_range(0, 511));
          else
            idx = 9'($urandom_range(0, lim - 1));
          send_req(make_req(fat16ca_pkg::ACT_READ, $urandom, idx), e);
          sent++;
        end else if (pick < 94) begin
          send_req(make_req(fat16ca_pkg::ACT_NONE, $urandom, 9'($urandom)), e);
          sent++;
        end else begin
          send_req(make_req(fat16ca_pkg::ACT_FORMAT, $urandom, 9'($urandom)), e);
          sent++;
        end
        if ($urandom_range(0, 39) == 0) drain(0);
      end
    end
  endtask

  initial begin
    wipe_mirror();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reads_at_reset();
    test_alloc_edges();
    test_limits();
    test_random();
    drain(1100);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
